// ===== hdl/bgpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgpm_pkg: shared constants and types of the button gesture pattern matcher
// Sizes, stream field offsets, register indexes, opcodes, record types and
// the sequencer states.
// ----------------------------------------------------------------------------
package bgpm_pkg;

  localparam int CHANNELS   = 4;
  localparam int EVENTS     = 4;
  localparam int LOG_DEPTH  = 4;
  localparam int SOURCES    = 8;
  localparam int RESULT_CAP = 16;

  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EV_W      = (EVENTS > 1) ? $clog2(EVENTS) : 1;
  localparam int ST_W      = $clog2(LOG_DEPTH);
  localparam int LEN_W     = $clog2(LOG_DEPTH + 1);
  localparam int TAB_DEPTH = EVENTS * LOG_DEPTH;
  localparam int TAB_W     = $clog2(TAB_DEPTH);
  localparam int NRES_W    = $clog2(RESULT_CAP + 1);

  // field widths fixed by the interface
  localparam int MS_W         = 32;
  localparam int DUR_W        = 16;
  localparam int SRC_FIELD_W  = 8;
  localparam int SEL_W        = 2;
  localparam int ID_W         = 2;
  localparam int PLEN_FIELD_W = 3;

  localparam int MASKS_W = 32;
  localparam int CHEN_W  = 4;
  localparam int EVEN_W  = 16;
  localparam int PLEN_W  = 12;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // input beat layout
  localparam int IN_NOW_LSB   = 0;
  localparam int IN_LVL_LSB   = 32;
  localparam int IN_EVSEL_LSB = 40;
  localparam int IN_STSEL_LSB = 42;
  localparam int IN_STLVL_LSB = 44;
  localparam int IN_MIN_LSB   = 45;
  localparam int IN_MAX_LSB   = 61;
  localparam int IN_DATA_W    = 80;

  localparam int OUT_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MASKS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ENABLES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_ENABLES   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTHS = 2'd3;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  typedef struct packed {
    logic            lvl;
    logic [MS_W-1:0] t;
  } log_ent_t;

  typedef struct packed {
    logic             lvl;
    logic [DUR_W-1:0] mn;
    logic [DUR_W-1:0] mx;
  } step_ent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAN,
    ST_EVENT,
    ST_STEP,
    ST_HIT,
    ST_FLUSH
  } state_e;

endpackage
`default_nettype wire

// ===== hdl/button_gesture_pattern_matcher_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_gesture_pattern_matcher_top: gesture matcher over timed level edges
// Logs level changes per channel and checks each enabled event pattern, one
// log entry per cycle through a shared subtract and compare unit.
// ----------------------------------------------------------------------------
//  port group   dir  beat contents
//  s_axis       in   tuser func, tdata now_ms..step_max_ms (tick or load)
//  m_axis       out  tdata channel_id, event_id, match_time_ms; tlast last
//  cfg          in   register index and data, written on cfg_we_i
//
//  a load beat is taken while idle; a tick then holds s_axis_tready low while
//  the sequencer visits each channel, each event of it, the steps of a checked
//  pattern and a hit state on a match, and then flushes the last result
//  the step walk reads one log entry and one pattern step per cycle
//  a stalled m_axis holds the sequencer only when a further result is ready
//  reset clears the config and control registers, the edge logs and the edge counters
// ----------------------------------------------------------------------------
module button_gesture_pattern_matcher_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // now_ms, source_levels, event_sel, step_sel, step_level, step_min_ms,
  // step_max_ms, zero pad
  input  wire logic [bgpm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // func
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // channel_id, event_id, match_time_ms, zero pad
  output logic [bgpm_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  output logic                                  m_axis_tlast,
  input  wire logic                             cfg_we_i,
  input  wire logic [bgpm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bgpm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bgpm_pkg::*;

  state_e state_q, state_d;

  logic [MASKS_W-1:0] source_masks_q;
  logic [CHEN_W-1:0]  channel_enables_q;
  logic [EVEN_W-1:0]  event_enables_q;
  logic [PLEN_W-1:0]  pattern_lengths_q;

  log_ent_t        log_q [CHANNELS][LOG_DEPTH];
  logic [LEN_W-1:0] cnt_q [CHANNELS][EVENTS];
  step_ent_t       tab_mem [TAB_DEPTH];

  logic [CH_W-1:0]   c_q;
  logic [EV_W-1:0]   e_q;
  logic [ST_W-1:0]   i_q;
  logic [NRES_W-1:0] n_q;
  logic [MS_W-1:0]   now_q;
  logic [SOURCES-1:0] levels_q;
  logic [MS_W-1:0]   ref_t_q;
  step_ent_t         rd_tab_q;

  logic            pend_valid_q;
  logic [ID_W-1:0] pend_ch_q, pend_ev_q;

  logic            out_valid_q;
  logic [ID_W-1:0] out_ch_q, out_ev_q;
  logic [MS_W-1:0] out_t_q;
  logic            out_last_q;

  // combinational
  logic             tick_acc, load_acc;
  logic             out_free, last_ev, last_ch;
  logic [SOURCES-1:0] mask;
  logic             act, chan_on, do_edge;
  logic             ev_on, ev_go;
  logic [PLEN_FIELD_W-1:0] len_raw;
  logic [LEN_W-1:0] len_c;
  log_ent_t         rd_log;
  logic [ST_W-1:0]  fetch_i;
  logic [ST_W-1:0]  step_idx;
  logic [TAB_W-1:0] tab_addr;
  logic [MS_W-1:0]  span;
  logic             step_ok, step_last;
  logic             advance, hit_fire, flush_fire, out_push, push_last;
  logic             load_ok;
  logic [TAB_W-1:0] load_addr;
  state_e           adv_state;
  int               ebit, pbase;

  // --------------------------------------------------------------------------
  // shared datapath
  // --------------------------------------------------------------------------
  always_comb begin
    for (int s = 0; s < SOURCES; s++) begin
      if (int'(c_q) * SRC_FIELD_W + SRC_FIELD_W <= MASKS_W) begin
        mask[s] = source_masks_q[int'(c_q) * SRC_FIELD_W + s];
      end else begin
        mask[s] = 1'b0;
      end
    end
    // empty mask reads as active
    act     = &(~mask | levels_q);
    chan_on = (int'(c_q) < CHEN_W) ? channel_enables_q[int'(c_q)] : 1'b0;

    rd_log  = log_q[c_q][i_q];
    do_edge = chan_on && (act != rd_log.lvl);

    ebit = EVENTS * int'(c_q) + int'(e_q);
    ev_on = (ebit < EVEN_W) ? event_enables_q[ebit] : 1'b0;

    pbase = PLEN_FIELD_W * int'(e_q);
    if (pbase + PLEN_FIELD_W <= PLEN_W) begin
      len_raw = pattern_lengths_q[pbase +: PLEN_FIELD_W];
    end else begin
      len_raw = '0;
    end
    len_c = (int'(len_raw) > LOG_DEPTH) ? LEN_W'(LOG_DEPTH) : LEN_W'(len_raw);

    ev_go = chan_on && ev_on && (len_c != '0) && (cnt_q[c_q][e_q] >= len_c)
            && (int'(n_q) < RESULT_CAP);

    // steps are fetched into the read register ahead of use: the first during the event check,
    // each following one while the current step is compared
    fetch_i  = (state_q == ST_STEP) ? ST_W'(i_q + ST_W'(1)) : '0;
    // pattern is stored oldest step first, the walk goes newest first
    step_idx = ST_W'(len_c - LEN_W'(1) - LEN_W'(fetch_i));
    tab_addr = TAB_W'(int'(e_q) * LOG_DEPTH + int'(step_idx));

    span      = ref_t_q - rd_log.t;
    step_ok   = (rd_tab_q.lvl == rd_log.lvl) && (span >= MS_W'(rd_tab_q.mn))
                && ((i_q == '0) || (rd_tab_q.mx == '0) || (span < MS_W'(rd_tab_q.mx)));
    step_last = (LEN_W'(i_q) + LEN_W'(1)) == len_c;

    last_ev = (e_q == EV_W'(EVENTS - 1));
    last_ch = (c_q == CH_W'(CHANNELS - 1));
    out_free = !out_valid_q || m_axis_tready;

    load_ok   = (int'(s_axis_tdata[IN_EVSEL_LSB +: SEL_W]) < EVENTS)
                && (int'(s_axis_tdata[IN_STSEL_LSB +: SEL_W]) < LOG_DEPTH);
    load_addr = TAB_W'(int'(s_axis_tdata[IN_EVSEL_LSB +: SEL_W]) * LOG_DEPTH
                + int'(s_axis_tdata[IN_STSEL_LSB +: SEL_W]));
  end

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    adv_state = last_ev ? (last_ch ? ST_FLUSH : ST_CHAN) : ST_EVENT;
    state_d   = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && (s_axis_tuser == FUNC_TICK)) state_d = ST_CHAN;
      end
      ST_CHAN: begin
        state_d = ST_EVENT;
      end
      ST_EVENT: begin
        state_d = ev_go ? ST_STEP : adv_state;
      end
      ST_STEP: begin
        if (!step_ok) state_d = adv_state;
        else if (step_last) state_d = ST_HIT;
      end
      ST_HIT: begin
        if (!pend_valid_q || out_free) state_d = adv_state;
      end
      ST_FLUSH: begin
        if (!pend_valid_q || out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    advance       = 1'b0;
    hit_fire      = 1'b0;
    flush_fire    = 1'b0;
    out_push      = 1'b0;
    push_last     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_EVENT: begin
        advance = !ev_go;
      end
      ST_STEP: begin
        advance = !step_ok;
      end
      ST_HIT: begin
        hit_fire = !pend_valid_q || out_free;
        advance  = hit_fire;
        out_push = hit_fire && pend_valid_q;
      end
      ST_FLUSH: begin
        flush_fire = pend_valid_q && out_free;
        out_push   = flush_fire;
        push_last  = 1'b1;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign tick_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_TICK);
  assign load_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_LOAD);

  // --------------------------------------------------------------------------
  // control and state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      source_masks_q    <= '0;
      channel_enables_q <= '0;
      event_enables_q   <= '0;
      pattern_lengths_q <= '0;
      c_q               <= '0;
      e_q               <= '0;
      i_q               <= '0;
      n_q               <= '0;
      pend_valid_q      <= 1'b0;
      out_valid_q       <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        for (int j = 0; j < LOG_DEPTH; j++) log_q[c][j] <= '0;
        for (int e = 0; e < EVENTS; e++) cnt_q[c][e] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SOURCE_MASKS:    source_masks_q    <= cfg_data_i[MASKS_W-1:0];
          CFG_CHANNEL_ENABLES: channel_enables_q <= cfg_data_i[CHEN_W-1:0];
          CFG_EVENT_ENABLES:   event_enables_q   <= cfg_data_i[EVEN_W-1:0];
          CFG_PATTERN_LENGTHS: pattern_lengths_q <= cfg_data_i[PLEN_W-1:0];
          default: ;
        endcase
      end

      if (tick_acc) begin
        c_q <= '0;
        e_q <= '0;
        i_q <= '0;
        n_q <= '0;
      end

      if (state_q == ST_CHAN && do_edge) begin
        for (int j = LOG_DEPTH - 1; j > 0; j--) log_q[c_q][j] <= log_q[c_q][j-1];
        log_q[c_q][0] <= '{lvl: act, t: now_q};
        for (int e = 0; e < EVENTS; e++) begin
          if (cnt_q[c_q][e] < LEN_W'(LOG_DEPTH)) cnt_q[c_q][e] <= cnt_q[c_q][e] + LEN_W'(1);
        end
      end

      if (state_q == ST_EVENT && ev_go) i_q <= '0;
      if (state_q == ST_STEP && step_ok && !step_last) i_q <= i_q + ST_W'(1);

      if (hit_fire) begin
        cnt_q[c_q][e_q] <= '0;
        n_q             <= n_q + NRES_W'(1);
        pend_valid_q    <= 1'b1;
      end
      if (flush_fire) pend_valid_q <= 1'b0;

      if (advance) begin
        i_q <= '0;
        if (last_ev) begin
          e_q <= '0;
          if (!last_ch) c_q <= c_q + CH_W'(1);
        end else begin
          e_q <= e_q + EV_W'(1);
        end
      end

      if (out_push) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      now_q    <= s_axis_tdata[IN_NOW_LSB +: MS_W];
      levels_q <= s_axis_tdata[IN_LVL_LSB +: SOURCES];
    end
    if (state_q == ST_EVENT) ref_t_q <= now_q;
    if (state_q == ST_STEP) ref_t_q <= rd_log.t;
    if (out_push) begin
      out_ch_q   <= pend_ch_q;
      out_ev_q   <= pend_ev_q;
      out_t_q    <= now_q;
      out_last_q <= push_last;
    end
    if (hit_fire) begin
      pend_ch_q <= ID_W'(c_q);
      pend_ev_q <= ID_W'(e_q);
    end
  end

  // pattern table, written by load beats only
  always_ff @(posedge clk_i) begin
    if (load_acc && load_ok) begin
      tab_mem[load_addr] <= '{lvl: s_axis_tdata[IN_STLVL_LSB],
                              mn:  s_axis_tdata[IN_MIN_LSB +: DUR_W],
                              mx:  s_axis_tdata[IN_MAX_LSB +: DUR_W]};
    end
    rd_tab_q <= tab_mem[tab_addr];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - MS_W - 2 * ID_W){1'b0}}, out_t_q, out_ev_q, out_ch_q};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !pend_valid_q)
    else $error("result still pending while idle");

  a_result_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(n_q) <= RESULT_CAP)
    else $error("result count beyond cap");

  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[c_q][e_q] <= LEN_W'(LOG_DEPTH))
    else $error("edge counter beyond log depth");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (LEN_W'(i_q) < len_c))
    else $error("step index beyond pattern length");

  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_fire |=> (m_axis_tvalid && m_axis_tlast && !pend_valid_q))
    else $error("final beat of a tick not marked last");

endmodule
`default_nettype wire

// ===== tb/sv/bgpm_gesture_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgpm_gesture_check: result checker for the button gesture pattern matcher
// Follows the register port and both streams, keeps its own edge logs, edge
// counters and pattern table, works out the matches of every tick beat and
// compares them in order with the result beats, field by field.
// ----------------------------------------------------------------------------
module bgpm_gesture_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // now_ms, source_levels, event_sel, step_sel, step_level, step_min_ms,
  // step_max_ms, zero pad
  input  logic [bgpm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func
  input  logic                            s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // channel_id, event_id, match_time_ms, zero pad
  input  logic [bgpm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [bgpm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bgpm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import bgpm_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0] ch;
    logic [ID_W-1:0] ev;
    logic [MS_W-1:0] at_ms;
    logic            last;
  } gesture_t;

  localparam int SRC_KEEP = (1 << SOURCES) - 1;

  logic [MASKS_W-1:0] masks_q;
  logic [CHEN_W-1:0]  chan_en_q;
  logic [EVEN_W-1:0]  event_en_q;
  logic [PLEN_W-1:0]  plen_q;

  log_ent_t    edge_hist  [CHANNELS][LOG_DEPTH];
  int unsigned edge_count [CHANNELS][EVENTS];
  step_ent_t   steps      [EVENTS][LOG_DEPTH];
  gesture_t    gestures_due [$];

  // lengths above the log depth count as the full depth
  function automatic int steps_needed(input int e);
    int n;
    if (PLEN_FIELD_W * e + PLEN_FIELD_W > PLEN_W) return 0;
    n = plen_q[PLEN_FIELD_W * e +: PLEN_FIELD_W];
    return (n > LOG_DEPTH) ? LOG_DEPTH : n;
  endfunction

  function automatic bit event_armed(input int c, input int e);
    if (4 * c + e >= EVEN_W) return 1'b0;
    return event_en_q[4 * c + e];
  endfunction

  // newest log entry against the last step, walking back in time
  function automatic bit pattern_fits(input int c, input int e, input int len,
                                      input logic [MS_W-1:0] now);
    step_ent_t       s;
    logic [MS_W-1:0] span;
    int              i;
    for (i = 0; i < len; i++) begin
      s = steps[e][len - 1 - i];
      if (s.lvl != edge_hist[c][i].lvl) return 1'b0;
      if (i == 0) begin
        span = now - edge_hist[c][0].t;
      end else begin
        span = edge_hist[c][i - 1].t - edge_hist[c][i].t;
      end
      if (span < s.mn) return 1'b0;
      if (i > 0 && s.mx != '0 && span >= s.mx) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_tick(input logic [MS_W-1:0] now,
                              input logic [SRC_FIELD_W-1:0] levels);
    gesture_t               hits [$];
    gesture_t               hit;
    logic [SRC_FIELD_W-1:0] m;
    logic                   act;
    int                     c, e, j, len;
    for (c = 0; c < CHANNELS; c++) begin
      if (c >= CHEN_W || !chan_en_q[c]) continue;
      m = '0;
      if (8 * c + 8 <= MASKS_W) m = masks_q[8 * c +: 8] & SRC_KEEP[SRC_FIELD_W-1:0];
      // an empty mask leaves the channel active
      act = ((levels & m) == m);
      if (act != edge_hist[c][0].lvl) begin
        for (j = LOG_DEPTH - 1; j > 0; j--) edge_hist[c][j] = edge_hist[c][j - 1];
        edge_hist[c][0].t   = now;
        edge_hist[c][0].lvl = act;
        for (e = 0; e < EVENTS; e++) begin
          if (edge_count[c][e] < LOG_DEPTH) edge_count[c][e]++;
        end
      end
      for (e = 0; e < EVENTS; e++) begin
        len = steps_needed(e);
        if (len == 0 || !event_armed(c, e) || edge_count[c][e] < len) continue;
        // past the cap a match is neither reported nor cleared
        if (hits.size() >= RESULT_CAP) continue;
        if (pattern_fits(c, e, len, now)) begin
          hit.ch    = c[ID_W-1:0];
          hit.ev    = e[ID_W-1:0];
          hit.at_ms = now;
          hit.last  = 1'b0;
          hits.push_back(hit);
          edge_count[c][e] = 0;
        end
      end
    end
    if (hits.size() > 0) hits[hits.size() - 1].last = 1'b1;
    foreach (hits[k]) gestures_due.push_back(hits[k]);
  endtask

  task automatic check_field(input string name, input logic [MS_W-1:0] want,
                             input logic [MS_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    gesture_t due;
    int       c, e, j;
    int       ev_sel, st_sel;
    if (!rst_ni) begin
      masks_q    = '0;
      chan_en_q  = '0;
      event_en_q = '0;
      plen_q     = '0;
      for (c = 0; c < CHANNELS; c++) begin
        for (j = 0; j < LOG_DEPTH; j++) edge_hist[c][j] = '0;
        for (e = 0; e < EVENTS; e++) edge_count[c][e] = 0;
      end
      for (e = 0; e < EVENTS; e++) begin
        for (j = 0; j < LOG_DEPTH; j++) steps[e][j] = '0;
      end
      gestures_due.delete();
      fail_count_o = 0;
    end else begin
      // results leave before this edge's input can have produced any
      if (m_axis_tvalid && m_axis_tready) begin
        if (gestures_due.size() == 0) begin
          $error("result beat with no match due: tdata %0h", m_axis_tdata);
          fail_count_o++;
        end else begin
          due = gestures_due.pop_front();
          check_field("channel_id", due.ch, m_axis_tdata[ID_W-1:0]);
          check_field("event_id", due.ev, m_axis_tdata[ID_W +: ID_W]);
          check_field("match_time_ms", due.at_ms, m_axis_tdata[2 * ID_W +: MS_W]);
          check_field("last_of_tick", due.last, m_axis_tlast);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SOURCE_MASKS:    masks_q    = cfg_data_i[MASKS_W-1:0];
          CFG_CHANNEL_ENABLES: chan_en_q  = cfg_data_i[CHEN_W-1:0];
          CFG_EVENT_ENABLES:   event_en_q = cfg_data_i[EVEN_W-1:0];
          CFG_PATTERN_LENGTHS: plen_q     = cfg_data_i[PLEN_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == FUNC_LOAD) begin
          ev_sel = s_axis_tdata[IN_EVSEL_LSB +: SEL_W];
          st_sel = s_axis_tdata[IN_STSEL_LSB +: SEL_W];
          if (ev_sel < EVENTS && st_sel < LOG_DEPTH) begin
            steps[ev_sel][st_sel].lvl = s_axis_tdata[IN_STLVL_LSB];
            steps[ev_sel][st_sel].mn  = s_axis_tdata[IN_MIN_LSB +: DUR_W];
            steps[ev_sel][st_sel].mx  = s_axis_tdata[IN_MAX_LSB +: DUR_W];
          end
        end else begin
          predict_tick(s_axis_tdata[IN_NOW_LSB +: MS_W],
                       s_axis_tdata[IN_LVL_LSB +: SRC_FIELD_W]);
        end
      end
    end
    pending_o = gestures_due.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for button_gesture_pattern_matcher_top
// Fills the pattern table, runs directed click, long press and wrap-around
// ticks, then random gesture-like tick streams with table loads over
// several register settings with bursty input and a stalling result side.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
  import bgpm_pkg::*;

  localparam int SETTLE_CYCLES   = 200;
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int PHASE_ITEMS     = 56;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = FUNC_TICK;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx       = CFG_SOURCE_MASKS;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  int fail_count;
  int pending;
  int burst_left   = 0;
  int quiet        = 0;

  button_gesture_pattern_matcher_top DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  bgpm_gesture_check u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: long ready stretches now and then, otherwise random stalls
  initial begin : result_stall
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(40, 160)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == WATCHDOG_CYCLES) begin
      $display("button_gesture_pattern_matcher_top: mismatch");
      $finish;
    end
  end

  // bursts of back-to-back beats separated by random gaps
  task automatic send_beat(input logic func, input logic [IN_DATA_W-1:0] data);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tuser  <= func;
    s_axis_tdata  <= data;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_tick(input logic [MS_W-1:0] now, input logic [SRC_FIELD_W-1:0] levels);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[IN_NOW_LSB +: MS_W]        = now;
    d[IN_LVL_LSB +: SRC_FIELD_W] = levels;
    send_beat(FUNC_TICK, d);
  endtask

  task automatic send_load(input logic [SEL_W-1:0] ev, input logic [SEL_W-1:0] st,
                           input logic lvl, input logic [DUR_W-1:0] mn,
                           input logic [DUR_W-1:0] mx);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[IN_EVSEL_LSB +: SEL_W] = ev;
    d[IN_STSEL_LSB +: SEL_W] = st;
    d[IN_STLVL_LSB]          = lvl;
    d[IN_MIN_LSB +: DUR_W]   = mn;
    d[IN_MAX_LSB +: DUR_W]   = mx;
    send_beat(FUNC_LOAD, d);
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] masks, input logic [CFG_DATA_W-1:0] chen,
                            input logic [CFG_DATA_W-1:0] even, input logic [CFG_DATA_W-1:0] plen);
    s_axis_tvalid <= 1'b0;
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SOURCE_MASKS;
    cfg_data <= masks;
    @(negedge clk);
    cfg_idx  <= CFG_CHANNEL_ENABLES;
    cfg_data <= chen;
    @(negedge clk);
    cfg_idx  <= CFG_EVENT_ENABLES;
    cfg_data <= even;
    @(negedge clk);
    cfg_idx  <= CFG_PATTERN_LENGTHS;
    cfg_data <= plen;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // all results in, then room for a tick that ends without one
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one or two sources per channel, so levels move often
  function automatic logic [MASKS_W-1:0] sparse_masks();
    logic [MASKS_W-1:0] m;
    int                 c;
    m = '0;
    for (c = 0; c < CHANNELS; c++) begin
      m[8 * c + $urandom_range(0, 7)] = 1'b1;
      if ($urandom_range(0, 1) == 1) m[8 * c + $urandom_range(0, 7)] = 1'b1;
    end
    return m;
  endfunction

  initial begin : stimulus
    logic [MS_W-1:0]        clock_ms;
    logic [SRC_FIELD_W-1:0] levels;
    logic [SEL_W-1:0]       ev, st;
    logic                   lvl;
    logic [DUR_W-1:0]       mn, mx;
    int                     phase, k, b;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // whole table first, so no unwritten step is ever read
    // event 0: click, press then release
    send_load(2'd0, 2'd0, 1'b1, 16'd30, 16'd300);
    send_load(2'd0, 2'd1, 1'b0, 16'd0, 16'd0);
    send_load(2'd0, 2'd2, 1'b1, 16'd10, 16'd400);
    send_load(2'd0, 2'd3, 1'b0, 16'd0, 16'd0);
    // event 1: long press
    send_load(2'd1, 2'd0, 1'b1, 16'd500, 16'd0);
    send_load(2'd1, 2'd1, 1'b0, 16'd0, 16'd0);
    send_load(2'd1, 2'd2, 1'b1, 16'd0, 16'd0);
    send_load(2'd1, 2'd3, 1'b0, 16'd0, 16'd0);
    // event 2: double click
    send_load(2'd2, 2'd0, 1'b1, 16'd20, 16'd300);
    send_load(2'd2, 2'd1, 1'b0, 16'd20, 16'd300);
    send_load(2'd2, 2'd2, 1'b1, 16'd20, 16'd300);
    send_load(2'd2, 2'd3, 1'b0, 16'd0, 16'd0);
    // event 3: duration extremes
    send_load(2'd3, 2'd0, 1'b0, 16'd0, 16'hFFFF);
    send_load(2'd3, 2'd1, 1'b1, 16'hFFFF, 16'd0);
    send_load(2'd3, 2'd2, 1'b0, 16'd0, 16'd1);
    send_load(2'd3, 2'd3, 1'b1, 16'd0, 16'd0);

    // channel 3 has an empty mask; event 3 length 7 clamps to the log depth
    write_regs(32'h00F0_0601, 32'hF, 32'hFFFF, 32'h0F0A);
    send_tick(32'd0, 8'h00);
    send_tick(32'd10, 8'h01);
    send_tick(32'd100, 8'h00);
    send_tick(32'd700, 8'hFF);
    send_tick(32'd1300, 8'hFF);
    send_tick(32'hFFFF_FFF0, 8'h00);
    send_tick(32'd16, 8'hFF);
    send_tick(32'hFFFF_FFFF, 8'h00);
    settle();

    phase    = 0;
    clock_ms = $urandom;
    levels   = '0;
    while (phase < 8) begin
      case (phase)
        0: write_regs(sparse_masks(), 32'hF, 32'hFFFF, 32'hFFF);
        1: write_regs(32'hFFFF_FFFF, 32'hF, 32'hFFFF, $urandom_range(0, 4095));
        2: write_regs(32'h0, $urandom_range(1, 15), $urandom_range(0, 65535),
                      $urandom_range(0, 4095));
        3: write_regs($urandom, 32'h0, 32'h0, 32'h0);
        default: write_regs(sparse_masks(), $urandom_range(1, 15), $urandom_range(0, 65535),
                            $urandom_range(0, 4095));
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          // steps mostly alternate in level so that real edge logs can match
          ev  = SEL_W'($urandom_range(0, EVENTS - 1));
          st  = SEL_W'($urandom_range(0, LOG_DEPTH - 1));
          lvl = ($urandom_range(0, 7) == 0) ? 1'($urandom_range(0, 1)) : (st[0] ^ ev[0]);
          if ($urandom_range(0, 15) == 0) begin
            mn = DUR_W'($urandom_range(0, 65535));
            mx = DUR_W'($urandom_range(0, 65535));
          end else begin
            mn = DUR_W'($urandom_range(0, 200));
            mx = ($urandom_range(0, 2) == 0) ? '0 : DUR_W'(32'(mn) + $urandom_range(1, 500));
          end
          send_load(ev, st, lvl, mn, mx);
        end else begin
          case ($urandom_range(0, 15))
            0: ;
            1: clock_ms = $urandom;
            default: clock_ms = clock_ms + $urandom_range(1, 250);
          endcase
          case ($urandom_range(0, 15))
            0: levels = 8'hFF;
            1: levels = 8'h00;
            2: levels = SRC_FIELD_W'($urandom_range(0, 255));
            default: begin
              for (b = 0; b < SRC_FIELD_W; b++) begin
                if ($urandom_range(0, 4) == 0) levels[b] = ~levels[b];
              end
            end
          endcase
          send_tick(clock_ms, levels);
        end
      end
      settle();
      phase++;
    end

    if (fail_count == 0 && pending == 0) begin
      $display("button_gesture_pattern_matcher_top: match");
    end else begin
      $display("button_gesture_pattern_matcher_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bgpm_pkg.sv
hdl/button_gesture_pattern_matcher_top.sv
tb/sv/bgpm_gesture_check.sv
tb/sv/tb.sv
